>>> hw/rtl/deq_pkg.sv
package deq_pkg;

   // Field widths of the request and response transactions.
   localparam int ACTION_W    = 2;
   localparam int VALUE_W     = 32;
   localparam int COUNT_OUT_W = 7;
   localparam int FAULT_W     = 2;

   // Action codes.
   localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 2'd3;

   // Fault codes.
   localparam logic [FAULT_W-1:0] FAULT_NONE  = 2'd0;
   localparam logic [FAULT_W-1:0] FAULT_EMPTY = 2'd1;
   localparam logic [FAULT_W-1:0] FAULT_FULL  = 2'd2;

   typedef struct packed {
      logic [ACTION_W-1:0]       action;
      logic signed [VALUE_W-1:0] item_value;
   } deq_req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] front_value;
      logic signed [VALUE_W-1:0] back_value;
      logic [COUNT_OUT_W-1:0]    entry_count;
      logic                      is_empty;
      logic [FAULT_W-1:0]        fault;
   } deq_rsp_type;

   // Shift and write commands broadcast to every cell of the chain.
   typedef struct packed {
      logic head_insert;
      logic head_remove;
      logic tail_write;
   } deq_cell_ctrl_type;

endpackage

>>> hw/rtl/deq_req_if.sv
interface deq_req_if;
   logic                 valid;
   logic                 ready;
   deq_pkg::deq_req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> hw/rtl/deq_rsp_if.sv
interface deq_rsp_if;
   logic                 valid;
   logic                 ready;
   deq_pkg::deq_rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> hw/rtl/deq_cell.sv
module deq_cell (
   input  logic                                 clock,
   input  deq_pkg::deq_cell_ctrl_type           ctrl,
   input  logic                                 write_sel,
   input  logic signed [deq_pkg::VALUE_W-1:0]   item_value,
   input  logic signed [deq_pkg::VALUE_W-1:0]   prev_data,
   input  logic signed [deq_pkg::VALUE_W-1:0]   next_data,
   output logic signed [deq_pkg::VALUE_W-1:0]   data
);
   import deq_pkg::*;

   logic signed [VALUE_W-1:0] data_ff;
   logic signed [VALUE_W-1:0] data_in;

   // A push at the front moves every entry one cell toward the back, a pop at the
   // front moves them one cell toward the front, and a push at the back writes
   // only the cell just past the last entry.
   always_comb begin
      if (ctrl.head_insert) begin
         data_in = prev_data;
      end else if (ctrl.head_remove) begin
         data_in = next_data;
      end else if (ctrl.tail_write && write_sel) begin
         data_in = item_value;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

>>> hw/rtl/deq_back_tree.sv
module deq_back_tree #(
   parameter int LEAVES = 64
) (
   input  logic                                clock,
   input  logic [LEAVES*deq_pkg::VALUE_W-1:0]  leaf_data,
   input  logic [LEAVES-1:0]                   leaf_sel,
   output logic [deq_pkg::VALUE_W-1:0]         root
);
   import deq_pkg::*;

   // Heap layout: node k combines nodes 2k and 2k+1, leaves sit at LEAVES and up.
   logic [VALUE_W-1:0] node_ff [1:2*LEAVES-1];

   // Leaf stage: at most one cell is selected, all others contribute zero.
   for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
      always_ff @(posedge clock) begin
         node_ff[LEAVES+i] <= leaf_sel[i] ? leaf_data[i*VALUE_W +: VALUE_W] : '0;
      end
   end

   // Each inner node registers the OR of its two children, one level per cycle.
   for (genvar k = 1; k < LEAVES; k++) begin : g_node
      always_ff @(posedge clock) begin
         node_ff[k] <= node_ff[2*k] | node_ff[2*k+1];
      end
   end

   assign root = node_ff[1];

endmodule

>>> hw/rtl/double_ended_queue_unit.sv
// Bounded double-ended queue of signed 32-bit values. Each request transaction
// pushes at the back or front, or pops from the front or back; each yields one
// response transaction with the front and back values (zero when empty), the
// entry count, an empty flag and a fault code (pop on empty or push on full,
// which leave the queue unchanged). Entries live in a chain of CAPACITY cells
// with the front always in the first cell, so the front is read directly; the
// back value is gathered through a registered binary OR tree over the cells.
// A new request is taken only once the previous one is finished: the sequencer
// waits for that readout tree to settle and for the output register to be free,
// then loads the response. A finished response waits in an output register while
// the next request is taken.
module double_ended_queue_unit #(
   parameter int CAPACITY = 64
) (
   input  logic      clock,
   input  logic      reset,
   deq_req_if.sink   req_port,
   deq_rsp_if.source rsp_port
);
   import deq_pkg::*;

   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int TREE_LOG = $clog2(CAPACITY);
   localparam int LEAVES   = 1 << TREE_LOG;
   localparam int SETTLE   = TREE_LOG + 1;
   localparam int SET_W    = $clog2(SETTLE + 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_BUSY = 1'b1;

   logic                      state_ff;
   logic                      state_in;
   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          count_in;
   logic [SET_W-1:0]          settle_ff;
   logic [SET_W-1:0]          settle_in;
   logic [FAULT_W-1:0]        fault_ff;
   logic [FAULT_W-1:0]        fault_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   deq_rsp_type               rsp_ff;
   deq_rsp_type               rsp_in;

   logic                      accept;
   logic                      full;
   logic                      empty;
   logic                      out_free;
   logic                      load;
   deq_cell_ctrl_type         cell_ctrl;
   logic [CAPACITY-1:0]       write_sel;
   logic signed [VALUE_W-1:0] cell_data [CAPACITY];
   logic [LEAVES*VALUE_W-1:0] leaf_data;
   logic [LEAVES-1:0]         leaf_sel;
   logic [VALUE_W-1:0]        back_root;
   logic [CNT_W+COUNT_OUT_W-1:0] count_wide;

   assign accept   = req_port.valid && req_port.ready;
   assign full     = (count_ff == CNT_W'(CAPACITY));
   assign empty    = (count_ff == '0);
   assign out_free = !rsp_valid_ff || rsp_port.ready;
   assign load     = (state_ff == ST_BUSY) && (settle_ff == SET_W'(SETTLE)) && out_free;

   assign req_port.ready = (state_ff == ST_IDLE);

   // Decode the action into chain commands, the new count and the fault code.
   always_comb begin
      cell_ctrl = '0;
      count_in  = count_ff;
      fault_in  = fault_ff;
      if (accept) begin
         fault_in = FAULT_NONE;
         case (req_port.payload.action)
            ACT_PUSH_BACK: begin
               if (full) begin
                  fault_in = FAULT_FULL;
               end else begin
                  cell_ctrl.tail_write = 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
            ACT_PUSH_FRONT: begin
               if (full) begin
                  fault_in = FAULT_FULL;
               end else begin
                  cell_ctrl.head_insert = 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
            ACT_POP_FRONT: begin
               if (empty) begin
                  fault_in = FAULT_EMPTY;
               end else begin
                  cell_ctrl.head_remove = 1'b1;
                  count_in = count_ff - 1'b1;
               end
            end
            default: begin
               if (empty) begin
                  fault_in = FAULT_EMPTY;
               end else begin
                  count_in = count_ff - 1'b1;
               end
            end
         endcase
      end
   end

   // The chain of cells; the first cell takes a value pushed at the front.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      assign write_sel[i] = (count_ff == CNT_W'(i));
      if (i == 0) begin : g_first
         deq_cell u_cell (
            .clock      (clock),
            .ctrl       (cell_ctrl),
            .write_sel  (write_sel[i]),
            .item_value (req_port.payload.item_value),
            .prev_data  (req_port.payload.item_value),
            .next_data  (cell_data[(i+1) % CAPACITY]),
            .data       (cell_data[i])
         );
      end else if (i == CAPACITY - 1) begin : g_last
         deq_cell u_cell (
            .clock      (clock),
            .ctrl       (cell_ctrl),
            .write_sel  (write_sel[i]),
            .item_value (req_port.payload.item_value),
            .prev_data  (cell_data[i-1]),
            .next_data  (cell_data[i]),
            .data       (cell_data[i])
         );
      end else begin : g_mid
         deq_cell u_cell (
            .clock      (clock),
            .ctrl       (cell_ctrl),
            .write_sel  (write_sel[i]),
            .item_value (req_port.payload.item_value),
            .prev_data  (cell_data[i-1]),
            .next_data  (cell_data[i+1]),
            .data       (cell_data[i])
         );
      end
   end

   // The back entry is the cell just before the count; unused leaves read zero.
   for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
      if (i < CAPACITY) begin : g_used
         assign leaf_data[i*VALUE_W +: VALUE_W] = cell_data[i];
         assign leaf_sel[i] = (count_ff == CNT_W'(i + 1));
      end else begin : g_pad
         assign leaf_data[i*VALUE_W +: VALUE_W] = '0;
         assign leaf_sel[i] = 1'b0;
      end
   end

   deq_back_tree #(
      .LEAVES (LEAVES)
   ) u_back_tree (
      .clock     (clock),
      .leaf_data (leaf_data),
      .leaf_sel  (leaf_sel),
      .root      (back_root)
   );

   // Sequencer: wait for the readout tree to settle and the output register to be free, then fill it.
   always_comb begin
      state_in  = state_ff;
      settle_in = settle_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in  = ST_BUSY;
               settle_in = '0;
            end
         end
         default: begin
            if (settle_ff != SET_W'(SETTLE)) begin
               settle_in = settle_ff + 1'b1;
            end
            if (load) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   // Response payload assembled from the chain head and the tree root.
   assign count_wide = {{COUNT_OUT_W{1'b0}}, count_ff};
   always_comb begin
      rsp_in             = rsp_ff;
      rsp_valid_in       = rsp_valid_ff && !rsp_port.ready;
      if (load) begin
         rsp_in.front_value = empty ? '0 : cell_data[0];
         rsp_in.back_value  = $signed(back_root);
         rsp_in.entry_count = count_wide[COUNT_OUT_W-1:0];
         rsp_in.is_empty    = empty;
         rsp_in.fault       = fault_ff;
         rsp_valid_in       = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         settle_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         settle_ff    <= settle_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fault_ff <= fault_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_port.valid   = rsp_valid_ff;
   assign rsp_port.payload = rsp_ff;

`ifndef SYNTHESIS
   // The count never runs past the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count exceeds capacity");

   // An empty queue reports zero at both ends.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.is_empty |-> rsp_ff.front_value == '0 &&
      rsp_ff.back_value == '0)
      else $error("empty queue reports a nonzero end value");

   // A push into a full queue is refused and leaves the count alone.
   a_full_refused: assert property (@(posedge clock) disable iff (reset)
      accept && full && (req_port.payload.action == ACT_PUSH_BACK ||
      req_port.payload.action == ACT_PUSH_FRONT) |=>
      fault_ff == FAULT_FULL && count_ff == $past(count_ff))
      else $error("push on full queue not refused");
`endif

endmodule
